/* sv/wtc_pkg.sv */
package wtc_pkg;

  // Item operation codes
  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_SET_TIME   = 3'd1,
    OP_ADD_COUNT  = 3'd2,
    OP_ADD_ALARM  = 3'd3,
    OP_REMOVE     = 3'd4
  } op_e;

  // Slot occupancy kind
  typedef enum logic [1:0] {
    KIND_FREE      = 2'd0,
    KIND_COUNTDOWN = 2'd1,
    KIND_ALARM     = 2'd2
  } kind_e;

  localparam int unsigned SEC_LAST  = 59;
  localparam int unsigned MIN_LAST  = 59;
  localparam int unsigned HOUR_LAST = 23;
  localparam int unsigned DAY_LAST  = 7;
  localparam int unsigned ALARM_W   = 14;

  // Input transaction
  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] seconds_value;
    logic [5:0]  minutes_in;
    logic [4:0]  hours_in;
    logic [2:0]  day_in;
    logic [7:0]  slot_in;
  } item_t;

  // Result transaction
  typedef struct packed {
    logic [7:0] fired_mask;
    logic       sync_request;
    logic [2:0] slot_out;
    logic       status;
    logic [5:0] clock_seconds;
    logic [5:0] clock_minutes;
    logic [4:0] clock_hours;
    logic [2:0] clock_weekday;
    logic [3:0] active_count;
  } result_t;

  // Command broadcast to every cell for the length of one walk
  typedef struct packed {
    logic               tick;
    logic               add_count;
    logic               add_alarm;
    logic               remove;
    logic [ALARM_W-1:0] now;
    logic [ALARM_W-1:0] alarm;
    logic [7:0]         slot;
  } cmd_t;

  // Token handed from cell to cell
  typedef struct packed {
    logic valid;
    logic claimed;
  } tok_t;

  // Per-cell event reported back to the controller
  typedef struct packed {
    logic freed;
    logic claimed;
  } evt_t;

  function automatic logic [ALARM_W-1:0] pack_alarm(logic [2:0] day, logic [4:0] hr,
                                                    logic [5:0] min);
    return {day, hr, min};
  endfunction

endpackage

/* sv/weekday_clock_with_task_slots.sv */
// The token walks the slot chain one cell per clock, from the launch register through
// every cell; the result strobes as the token leaves the last cell, and busy stays
// high until the token leaves the last cell, so the walks of two transactions never overlap.
// The receiver cannot stall: done_o is high for exactly one cycle per transaction.
// Reset (asynchronous, active low) clears the clock to invalid time, frees every
// slot and loads the correction interval with 3600; no clearing pass is needed.
module weekday_clock_with_task_slots #(
  parameter int unsigned SLOTS       = 8,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  wtc_pkg::item_t          item_i,
  output logic                    done_o,
  output wtc_pkg::result_t        res_o,
  input  logic                    cfg_we_i,
  input  logic [15:0]             cfg_wdata_i
);

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned OCC_W = $clog2(SLOTS + 1);

  logic [15:0]            interval_q;
  logic [5:0]             sec_q, sec_d;
  logic [5:0]             min_q, min_d;
  logic [4:0]             hour_q, hour_d;
  logic [2:0]             day_q, day_d;
  logic [15:0]            sync_cnt_q, sync_cnt_d;
  logic [16:0]            sync_sum;
  logic                   sync_q, sync_d;
  logic                   is_add_q, is_add_d;
  logic [OCC_W-1:0]       occ_q, occ_d;
  logic [SLOTS-1:0]       fired_q, fired_d;
  logic [IDX_W-1:0]       slot_q, slot_d;
  wtc_pkg::cmd_t          cmd_q, cmd_d;
  logic [COUNT_WIDTH-1:0] load_q, load_d;
  wtc_pkg::tok_t          launch_q, launch_d;
  wtc_pkg::tok_t          tok [SLOTS+1];
  wtc_pkg::evt_t          evt [SLOTS];
  logic [SLOTS:0]         tok_vld;
  logic                   accept, any_freed, any_claimed;

  assign tok[0] = launch_q;

  // Chain of slot cells
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    wtc_cell #(
      .COUNT_WIDTH (COUNT_WIDTH),
      .IDX         (i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (tok[i]),
      .tok_o  (tok[i+1]),
      .cmd_i  (cmd_q),
      .load_i (load_q),
      .evt_o  (evt[i])
    );
  end

  // Busy while the token is anywhere before the last cell output
  always_comb begin
    busy = 1'b0;
    for (int i = 0; i <= SLOTS; i++) begin
      tok_vld[i] = tok[i].valid;
    end
    for (int i = 0; i < SLOTS; i++) begin
      busy = busy | tok[i].valid;
    end
  end

  assign accept = start && !busy;

  // Decode the transaction, advance the clock, launch the token
  always_comb begin
    sec_d      = sec_q;
    min_d      = min_q;
    hour_d     = hour_q;
    day_d      = day_q;
    sync_cnt_d = sync_cnt_q;
    sync_d     = sync_q;
    is_add_d   = is_add_q;
    cmd_d      = cmd_q;
    load_d     = load_q;
    launch_d   = '0;
    sync_sum   = {1'b0, sync_cnt_q} + 17'd1;
    if (accept) begin
      launch_d.valid = 1'b1;
      sync_d         = 1'b0;
      is_add_d       = 1'b0;
      cmd_d          = '0;
      cmd_d.slot     = item_i.slot_in;
      cmd_d.alarm    = wtc_pkg::pack_alarm(item_i.day_in, item_i.hours_in, item_i.minutes_in);
      load_d         = COUNT_WIDTH'(item_i.seconds_value);
      case (wtc_pkg::op_e'(item_i.op))
        wtc_pkg::OP_TICK: begin
          if (day_q != 3'd0) begin
            cmd_d.tick = 1'b1;
            if (sec_q >= 6'(wtc_pkg::SEC_LAST)) begin
              sec_d = 6'd0;
              if (min_q >= 6'(wtc_pkg::MIN_LAST)) begin
                min_d = 6'd0;
                if (hour_q >= 5'(wtc_pkg::HOUR_LAST)) begin
                  hour_d = 5'd0;
                  day_d  = (day_q >= 3'(wtc_pkg::DAY_LAST)) ? 3'd1 : day_q + 3'd1;
                end else begin
                  hour_d = hour_q + 5'd1;
                end
              end else begin
                min_d = min_q + 6'd1;
              end
            end else begin
              sec_d = sec_q + 6'd1;
            end
            if (sync_sum >= {1'b0, interval_q}) begin
              sync_cnt_d = 16'd0;
              sync_d     = 1'b1;
            end else begin
              sync_cnt_d = sync_sum[15:0];
            end
          end else begin
            sync_d = 1'b1;
          end
        end
        wtc_pkg::OP_SET_TIME: begin
          sec_d  = item_i.seconds_value[5:0];
          min_d  = item_i.minutes_in;
          hour_d = item_i.hours_in;
          day_d  = item_i.day_in;
        end
        wtc_pkg::OP_ADD_COUNT: begin
          cmd_d.add_count = 1'b1;
          is_add_d        = 1'b1;
        end
        wtc_pkg::OP_ADD_ALARM: begin
          cmd_d.add_alarm = 1'b1;
          is_add_d        = 1'b1;
        end
        wtc_pkg::OP_REMOVE: begin
          cmd_d.remove = 1'b1;
        end
        default: begin
        end
      endcase
    end
    cmd_d.now = wtc_pkg::pack_alarm(day_d, hour_d, min_d);
  end

  // Collect cell events into the mask, the slot taken and the occupancy
  always_comb begin
    fired_d     = accept ? '0 : fired_q;
    slot_d      = accept ? '0 : slot_q;
    any_freed   = 1'b0;
    any_claimed = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (evt[i].freed) begin
        any_freed = 1'b1;
        if (cmd_q.tick) begin
          fired_d[i] = 1'b1;
        end
      end
      if (evt[i].claimed) begin
        any_claimed = 1'b1;
        slot_d      = IDX_W'(i);
      end
    end
    occ_d = occ_q;
    if (any_claimed) begin
      occ_d = occ_q + OCC_W'(1);
    end else if (any_freed && (occ_q != '0)) begin
      occ_d = occ_q - OCC_W'(1);
    end
  end

  // Control and clock registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= 16'd3600;
      sec_q      <= '0;
      min_q      <= '0;
      hour_q     <= '0;
      day_q      <= '0;
      sync_cnt_q <= '0;
      occ_q      <= '0;
      launch_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        interval_q <= cfg_wdata_i;
      end
      sec_q      <= sec_d;
      min_q      <= min_d;
      hour_q     <= hour_d;
      day_q      <= day_d;
      sync_cnt_q <= sync_cnt_d;
      occ_q      <= occ_d;
      launch_q   <= launch_d;
    end
  end

  // Transaction payload
  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    load_q   <= load_d;
    sync_q   <= sync_d;
    is_add_q <= is_add_d;
    fired_q  <= fired_d;
    slot_q   <= slot_d;
  end

  // Present the result as the token leaves the last cell
  assign done_o = tok[SLOTS].valid;
  always_comb begin
    res_o.fired_mask    = 8'(fired_q);
    res_o.sync_request  = sync_q;
    res_o.slot_out      = tok[SLOTS].claimed ? 3'(slot_q) : 3'd0;
    res_o.status        = is_add_q && !tok[SLOTS].claimed;
    res_o.clock_seconds = sec_q;
    res_o.clock_minutes = min_q;
    res_o.clock_hours   = hour_q;
    res_o.clock_weekday = day_q;
    res_o.active_count  = 4'(occ_q);
  end

`ifndef SYNTH
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vld)) else $error("more than one token in the slot chain");
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result strobed while still busy");
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OCC_W'(SLOTS)) else $error("occupancy above slot count");
  a_full_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.status) |-> (occ_q == OCC_W'(SLOTS)))
    else $error("add failed with a free slot");
  a_launch_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> launch_q.valid) else $error("accepted transaction not launched");
`endif

endmodule

/* sv/wtc_cell.sv */
module wtc_cell #(
  parameter int unsigned COUNT_WIDTH = 16,
  parameter int unsigned IDX         = 0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  wtc_pkg::tok_t          tok_i,
  output wtc_pkg::tok_t          tok_o,
  input  wtc_pkg::cmd_t          cmd_i,
  input  logic [COUNT_WIDTH-1:0] load_i,
  output wtc_pkg::evt_t          evt_o
);

  wtc_pkg::kind_e                   kind_q, kind_d;
  logic [COUNT_WIDTH-1:0]           rem_q, rem_d;
  logic [wtc_pkg::ALARM_W-1:0]      alarm_q, alarm_d;
  wtc_pkg::tok_t                    tok_q, tok_d;
  logic                             act, is_free, claim, fire, drop;

  // Act on this slot while the token sits here
  always_comb begin
    act     = tok_i.valid;
    is_free = (kind_q == wtc_pkg::KIND_FREE);
    claim   = act && (cmd_i.add_count || cmd_i.add_alarm) && is_free && !tok_i.claimed;
    fire    = 1'b0;
    if (act && cmd_i.tick) begin
      case (kind_q)
        wtc_pkg::KIND_COUNTDOWN: fire = (rem_q == COUNT_WIDTH'(1));
        wtc_pkg::KIND_ALARM:     fire = (alarm_q == cmd_i.now);
        default:                 fire = 1'b0;
      endcase
    end
    drop = act && cmd_i.remove && !is_free && (cmd_i.slot == 8'(IDX));

    kind_d  = kind_q;
    rem_d   = rem_q;
    alarm_d = alarm_q;
    if (act && cmd_i.tick && (kind_q == wtc_pkg::KIND_COUNTDOWN)) begin
      rem_d = rem_q - COUNT_WIDTH'(1);
    end
    if (fire || drop) begin
      kind_d = wtc_pkg::KIND_FREE;
    end
    if (claim && cmd_i.add_count) begin
      kind_d = wtc_pkg::KIND_COUNTDOWN;
      rem_d  = load_i;
    end
    if (claim && cmd_i.add_alarm) begin
      kind_d  = wtc_pkg::KIND_ALARM;
      alarm_d = cmd_i.alarm;
    end

    tok_d.valid   = tok_i.valid;
    tok_d.claimed = tok_i.claimed | claim;
  end

  assign evt_o.freed   = fire | drop;
  assign evt_o.claimed = claim;
  assign tok_o         = tok_q;

  // Hold slot kind and pass the token on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= wtc_pkg::KIND_FREE;
      tok_q  <= '0;
    end else begin
      kind_q <= kind_d;
      tok_q  <= tok_d;
    end
  end

  // Slot payload
  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    alarm_q <= alarm_d;
  end

endmodule
